### sv/bss_pkg.sv
// Shared types, sizes and operation codes for the bounded stack with sort.
package bss_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PHS_W  = $clog2(DEPTH);
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_SORT = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic push;    // take word from the cell above
		logic pop;     // take word from the cell below
		logic cmp_en;  // compare and swap with the cell below
	} cell_ctl_t;

endpackage

### sv/bounded_stack_with_sort_top.sv
// Bounded stack with sort: top level with control and the row of entry cells.
// Push, pop and the unused kind: a transfer is accepted when start is high
// and busy is low, and the result appears on the next cycle with done high for one cycle;
// a new command may be given in that same cycle. Sort runs an odd-even transposition over
// the cell row, one phase per cycle, for DEPTH phases; the S_FIN state then latches the result,
// busy falls as it ends, and done is high in the first cycle after busy falls.
// The receiver cannot stall: it is to take each result as valid only in its done cycle.
module bounded_stack_with_sort_top
	import bss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  word_t       value,
	output logic        done,
	output logic [1:0]  status,
	output word_t       popped_value,
	output word_t       top_value,
	output logic        is_empty,
	output logic        is_full,
	output logic [4:0]  occupancy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SORT = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q;
	cnt_t             cnt_q;
	logic [PHS_W-1:0] phase_q;
	logic             done_q;
	logic [1:0]       status_q;
	word_t            popped_q;
	word_t            top_q;

	cell_ctl_t ctl [DEPTH];
	word_t     cell_data [DEPTH];
	logic      cell_swap [DEPTH];

	logic acc, full, empty, do_push, do_pop;

	assign busy  = (state_q != S_IDLE);
	assign acc   = start && !busy;
	assign full  = (cnt_q == cnt_t'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = acc && (kind == KIND_PUSH) && !full;
	assign do_pop  = acc && (kind == KIND_POP) && !empty;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].push   = do_push;
			ctl[i].pop    = do_pop;
			ctl[i].cmp_en = (state_q == S_SORT) && (1'(i) == phase_q[0])
			                && (i < DEPTH - 1) && (cnt_t'(i + 1) < cnt_q);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		word_t up_v, dn_v;
		logic  sw_up;
		if (g == 0) begin : g_first
			assign up_v  = value;
			assign sw_up = 1'b0;
		end else begin : g_mid
			assign up_v  = cell_data[g-1];
			assign sw_up = cell_swap[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign dn_v = '0;
		end else begin : g_nlast
			assign dn_v = cell_data[g+1];
		end
		bss_cell u_cell (
			.clk     (clk),
			.ctl     (ctl[g]),
			.up_val  (up_v),
			.dn_val  (dn_v),
			.swap_up (sw_up),
			.data    (cell_data[g]),
			.swap_dn (cell_swap[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			phase_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (kind == KIND_SORT) begin
							state_q <= S_SORT;
							phase_q <= '0;
						end else begin
							done_q <= 1'b1;
						end
						if (do_push) cnt_q <= cnt_q + cnt_t'(1);
						if (do_pop)  cnt_q <= cnt_q - cnt_t'(1);
					end
				end
				S_SORT: begin
					phase_q <= phase_q + PHS_W'(1);
					if (phase_q == PHS_W'(DEPTH - 1)) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			status_q <= ST_OK;
			popped_q <= '0;
			top_q    <= empty ? word_t'(0) : cell_data[0];
		end else if (acc) begin
			status_q <= ST_OK;
			popped_q <= '0;
			top_q    <= empty ? word_t'(0) : cell_data[0];
			case (kind)
				KIND_PUSH: begin
					if (full) status_q <= ST_OVERFLOW;
					else      top_q    <= value;
				end
				KIND_POP: begin
					if (empty) begin
						status_q <= ST_UNDERFLOW;
					end else begin
						popped_q <= cell_data[0];
						top_q    <= (cnt_q > cnt_t'(1)) ? cell_data[1] : word_t'(0);
					end
				end
				default: ;
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign top_value    = top_q;
	assign is_empty     = empty;
	assign is_full      = full;
	assign occupancy    = 5'(cnt_q);

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> done_q)
		else $error("sort finish without result strobe");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(DEPTH))
		else $error("entry count beyond depth");

	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (kind != KIND_SORT)) |=> (done_q && !busy))
		else $error("push/pop result missing");

	a_sort_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SORT) |=> $stable(cnt_q))
		else $error("count changed during sort");

endmodule

### sv/bss_cell.sv
// One stack entry: shifts with push and pop, compare-exchanges with its lower neighbor.
module bss_cell
	import bss_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  word_t     up_val,
	input  word_t     dn_val,
	input  logic      swap_up,
	output word_t     data,
	output logic      swap_dn
);

	word_t data_q;

	assign data    = data_q;
	assign swap_dn = ctl.cmp_en && (data_q > dn_val);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= up_val;
		end else if (ctl.pop || swap_dn) begin
			data_q <= dn_val;
		end else if (swap_up) begin
			data_q <= up_val;
		end
	end

endmodule
